// ----- design/dwpi_pkg.sv -----
// Shared constants and arithmetic helpers for the dual wheel PI speed controller.
// No dependencies.
package dwpi_pkg;

    localparam int RAMP_DIVIDE    = 10;
    localparam int COUNTS_PER_REV = 1024;
    localparam int MS_PER_MIN     = 60000;
    localparam int MAX_TARGET_RPM = 9920;
    localparam int MIN_RAMP_RATE  = 100;
    localparam int RAMP_STEP_DIV  = 100;
    localparam int DUTY_MAX       = 32767;

    localparam int TICK_W = $clog2(RAMP_DIVIDE + 1);

    // rate / 100 as multiply by reciprocal, exact for 15 bit rates
    localparam int            RAMP_SHIFT  = 22;
    localparam longint        RAMP_RECIP_L = ((longint'(1) << RAMP_SHIFT) + RAMP_STEP_DIV - 1)
                                             / RAMP_STEP_DIV;
    localparam logic [15:0]   RAMP_RECIP  = 16'(RAMP_RECIP_L);

    // |rpm| * COUNTS_PER_REV / 60000 as multiply by reciprocal, exact for 16 bit magnitudes
    localparam int            EXP_SHIFT   = 26;
    localparam longint        EXP_RECIP_L = ((longint'(1) << EXP_SHIFT) * COUNTS_PER_REV
                                             + MS_PER_MIN - 1) / MS_PER_MIN;
    localparam logic [20:0]   EXP_RECIP   = 21'(EXP_RECIP_L);

    localparam int EXPECT_W = 11;
    localparam int STEP_W   = 9;

    typedef enum logic [2:0] {
        REG_TARGET_LEFT  = 3'd0,
        REG_TARGET_RIGHT = 3'd1,
        REG_RAMP_LEFT    = 3'd2,
        REG_RAMP_RIGHT   = 3'd3,
        REG_PROP_GAIN    = 3'd4,
        REG_INTEG_GAIN   = 3'd5,
        REG_INTEG_LIMIT  = 3'd6
    } cfg_reg_t;

    function automatic logic [STEP_W-1:0] ramp_step(input logic [14:0] rate);
        logic [14:0] r;
        logic [30:0] prod;
        r    = (rate < 15'(MIN_RAMP_RATE)) ? 15'(MIN_RAMP_RATE) : rate;
        prod = {16'd0, r} * {15'd0, RAMP_RECIP};
        return prod[RAMP_SHIFT +: STEP_W];
    endfunction

    function automatic logic signed [15:0] ramp_toward(input logic signed [15:0] now,
                                                       input logic signed [15:0] tgt,
                                                       input logic [STEP_W-1:0] step);
        logic signed [16:0] up;
        logic signed [16:0] dn;
        logic signed [16:0] tgt_x;
        logic signed [15:0] res;
        tgt_x = $signed({tgt[15], tgt});
        up    = $signed({now[15], now}) + $signed({8'd0, step});
        dn    = $signed({now[15], now}) - $signed({8'd0, step});
        if (now < tgt) begin
            res = (up > tgt_x) ? tgt : up[15:0];
        end else begin
            res = (dn < tgt_x) ? tgt : dn[15:0];
        end
        return res;
    endfunction

    function automatic logic signed [EXPECT_W-1:0] rpm_to_counts(input logic signed [15:0] sp);
        logic [16:0]         mag;
        logic [37:0]         prod;
        logic [EXPECT_W-1:0] q;
        mag  = sp[15] ? (17'd0 - {1'b1, sp}) : {1'b0, sp};
        prod = {21'd0, mag} * {17'd0, EXP_RECIP};
        q    = prod[EXP_SHIFT +: EXPECT_W];
        return sp[15] ? $signed(EXPECT_W'(0) - q) : $signed(q);
    endfunction

endpackage

// ----- design/dual_wheel_pi_speed_controller_top.sv -----
// Dual wheel PI speed controller: setpoint ramp, count error, clamped PI law, duty output.
// Depends on dwpi_pkg.
//
// Usage:
//   Input channel s_*: one transaction per 1 ms tick with the signed encoder count
//   deltas of both wheels. Result channel m_*: one transaction per input, carrying
//   duty magnitude and reverse bit for each wheel. Configuration channel cfg_*:
//   register index and data, always ready; write only while the block is idle.
//   Every tenth tick the setpoints step toward the targets before control runs.
//   Pipeline: an accepted input transaction passes the ramp, count conversion,
//   integrator and PI output registers in turn before its result is presented.
//   Throughput: one transaction per cycle unless a waiting result stalls, set by the integrator loop.
//   Reset (aresetn low, synchronous) clears the pipeline, the tick counter,
//   setpoints and integrators, and loads the default register values.
//   When m_ready is low with a result waiting, the whole pipeline holds and
//   s_ready drops; nothing is lost or repeated.
module dual_wheel_pi_speed_controller_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_enc_delta_left,
    input  logic [15:0] s_enc_delta_right,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [14:0] m_duty_left,
    output logic        m_reverse_left,
    output logic [14:0] m_duty_right,
    output logic        m_reverse_right,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import dwpi_pkg::*;

    // configuration
    logic signed [15:0]  target_reg [2];
    logic [STEP_W-1:0]   step_reg [2];
    logic [7:0]          prop_reg;
    logic [7:0]          integ_gain_reg;
    logic [13:0]         limit_reg;

    // state
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic signed [15:0]  sp_reg [2];
    logic signed [15:0]  sp_next [2];
    logic signed [14:0]  integ_reg [2];
    logic signed [14:0]  integ_next [2];

    // pipeline
    logic                s1_valid_reg, s2_valid_reg, s3_valid_reg, m_valid_reg;
    logic signed [15:0]  s1_sp_reg [2];
    logic signed [15:0]  s1_enc_reg [2];
    logic signed [EXPECT_W-1:0] s2_expect_reg [2];
    logic signed [15:0]  s2_enc_reg [2];
    logic signed [17:0]  s3_err_reg [2];
    logic signed [14:0]  s3_acc_reg [2];
    logic [14:0]         duty_reg [2];
    logic [14:0]         duty_next [2];
    logic                rev_reg [2];
    logic                rev_next [2];

    logic                adv;
    logic                s_take;
    logic [TICK_W-1:0]   tick_inc;
    logic                ramp_now;
    logic signed [15:0]  enc_in [2];
    logic signed [17:0]  err_c [2];
    logic signed [18:0]  acc_c [2];
    logic signed [18:0]  lim_c;
    logic signed [26:0]  p_term [2];
    logic signed [26:0]  i_term [2];
    logic signed [27:0]  u_c [2];
    logic signed [27:0]  u_sat [2];
    logic [27:0]         u_mag [2];

    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = adv;
    assign s_take    = s_valid && adv;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_duty_left     = duty_reg[0];
    assign m_reverse_left  = rev_reg[0];
    assign m_duty_right    = duty_reg[1];
    assign m_reverse_right = rev_reg[1];
    assign enc_in[0] = $signed(s_enc_delta_left);
    assign enc_in[1] = $signed(s_enc_delta_right);

    always_comb begin
        tick_inc  = tick_reg + TICK_W'(1);
        ramp_now  = (tick_inc >= TICK_W'(RAMP_DIVIDE));
        tick_next = tick_reg;
        if (s_take) begin
            tick_next = ramp_now ? '0 : tick_inc;
        end
        lim_c = $signed({5'd0, limit_reg});
        for (int w = 0; w < 2; w++) begin
            sp_next[w] = (s_take && ramp_now) ?
                         ramp_toward(sp_reg[w], target_reg[w], step_reg[w]) : sp_reg[w];

            err_c[w] = $signed({{7{s2_expect_reg[w][EXPECT_W-1]}}, s2_expect_reg[w]})
                     - $signed({{2{s2_enc_reg[w][15]}}, s2_enc_reg[w]});
            acc_c[w] = $signed({{4{integ_reg[w][14]}}, integ_reg[w]})
                     + $signed({err_c[w][17], err_c[w]});
            if (acc_c[w] > lim_c) begin
                integ_next[w] = lim_c[14:0];
            end else if (acc_c[w] < -lim_c) begin
                integ_next[w] = 15'(-lim_c);
            end else begin
                integ_next[w] = acc_c[w][14:0];
            end

            p_term[w] = 27'($signed({1'b0, prop_reg})) * 27'(s3_err_reg[w]);
            i_term[w] = 27'($signed({1'b0, integ_gain_reg})) * 27'(s3_acc_reg[w]);
            u_c[w]    = 28'(p_term[w]) + 28'(i_term[w]);
            if (u_c[w] > 28'sd32767) begin
                u_sat[w] = 28'(DUTY_MAX);
            end else if (u_c[w] < -28'sd32767) begin
                u_sat[w] = -28'(DUTY_MAX);
            end else begin
                u_sat[w] = u_c[w];
            end
            rev_next[w]  = u_sat[w][27];
            u_mag[w]     = u_sat[w][27] ? (28'd0 - u_sat[w]) : u_sat[w];
            duty_next[w] = u_mag[w][14:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            prop_reg       <= 8'd20;
            integ_gain_reg <= 8'd3;
            limit_reg      <= 14'd3000;
            for (int w = 0; w < 2; w++) begin
                target_reg[w] <= '0;
                step_reg[w]   <= ramp_step(15'(MIN_RAMP_RATE));
                sp_reg[w]     <= '0;
                integ_reg[w]  <= '0;
            end
        end else begin
            tick_reg <= tick_next;
            for (int w = 0; w < 2; w++) begin
                sp_reg[w] <= sp_next[w];
            end
            if (adv) begin
                s1_valid_reg <= s_valid;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                m_valid_reg  <= s3_valid_reg;
                if (s2_valid_reg) begin
                    for (int w = 0; w < 2; w++) begin
                        integ_reg[w] <= integ_next[w];
                    end
                end
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_TARGET_LEFT, REG_TARGET_RIGHT: begin
                        target_reg[cfg_index[0]] <= ($signed(cfg_data) > MAX_TARGET_RPM) ?
                                                    16'(MAX_TARGET_RPM) : $signed(cfg_data);
                    end
                    REG_RAMP_LEFT, REG_RAMP_RIGHT: begin
                        step_reg[cfg_index[0]] <= ramp_step(cfg_data[14:0]);
                    end
                    REG_PROP_GAIN:   prop_reg       <= cfg_data[7:0];
                    REG_INTEG_GAIN:  integ_gain_reg <= cfg_data[7:0];
                    REG_INTEG_LIMIT: limit_reg      <= cfg_data[13:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int w = 0; w < 2; w++) begin
                s1_sp_reg[w]     <= sp_next[w];
                s1_enc_reg[w]    <= enc_in[w];
                s2_expect_reg[w] <= rpm_to_counts(s1_sp_reg[w]);
                s2_enc_reg[w]    <= s1_enc_reg[w];
                s3_err_reg[w]    <= err_c[w];
                s3_acc_reg[w]    <= integ_next[w];
                duty_reg[w]      <= duty_next[w];
                rev_reg[w]       <= rev_next[w];
            end
        end
    end

endmodule
